// ----- hdl/gifd_pkg.sv -----
// Package for the GIF container deframer: event and error codes, parser states
// and the result record. No dependencies.
package gifd_pkg;

    localparam logic [31:0] SIGNATURE = 32'h38464947;
    localparam logic [7:0] ID_IMAGE = 8'h2C;
    localparam logic [7:0] ID_EXT = 8'h21;
    localparam logic [7:0] ID_TRAILER = 8'h3B;
    localparam logic [7:0] LBL_GCE = 8'hF9;
    localparam logic [7:0] LBL_APP = 8'hFF;
    localparam logic [7:0] LBL_COMMENT = 8'hFE;
    localparam logic [7:0] LBL_TEXT = 8'h01;
    localparam logic [3:0] APP_HDR_LAST = 4'd11;
    localparam logic [8:0] NO_TRANSPARENT = 9'd256;

    localparam logic [3:0] EV_SCREEN = 4'd0;
    localparam logic [3:0] EV_GLOBAL = 4'd1;
    localparam logic [3:0] EV_GCE = 4'd2;
    localparam logic [3:0] EV_IMAGE = 4'd3;
    localparam logic [3:0] EV_LOCAL = 4'd4;
    localparam logic [3:0] EV_CODESIZE = 4'd5;
    localparam logic [3:0] EV_DATA = 4'd6;
    localparam logic [3:0] EV_DATA_END = 4'd7;
    localparam logic [3:0] EV_STREAM_END = 4'd8;
    localparam logic [3:0] EV_ERROR = 4'd9;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_HEADER = 3'd1;
    localparam logic [2:0] ERR_BLOCK_ID = 3'd2;
    localparam logic [2:0] ERR_LABEL = 3'd3;
    localparam logic [2:0] ERR_CODE_SIZE = 3'd4;

    typedef enum logic [16:0] {
        ST_SIG      = 17'h00001,
        ST_VER      = 17'h00002,
        ST_SCREEN   = 17'h00004,
        ST_GPAL     = 17'h00008,
        ST_BLOCK    = 17'h00010,
        ST_LABEL    = 17'h00020,
        ST_GCE      = 17'h00040,
        ST_APPHDR   = 17'h00080,
        ST_SUBCNT   = 17'h00100,
        ST_SUBDATA  = 17'h00200,
        ST_IMGDESC  = 17'h00400,
        ST_LPAL     = 17'h00800,
        ST_CODESIZE = 17'h01000,
        ST_DATACNT  = 17'h02000,
        ST_DATA     = 17'h04000,
        ST_DONE     = 17'h08000,
        ST_ERROR    = 17'h10000
    } state_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [7:0]  data_byte;
        logic [15:0] delay_time;
        logic [23:0] palette_rgb;
        logic [8:0]  color_index;
        logic [7:0]  packed_flags;
        logic [15:0] top;
        logic [15:0] left;
        logic [15:0] height;
        logic [15:0] width;
        logic [3:0]  event_kind;
    } result_t;

endpackage

// ----- hdl/gif_container_deframer.sv -----
// GIF container deframer top level: one-byte-per-clock parser state machine.
// Depends on gifd_pkg.
//
// Takes one file byte per clock on s_axis and yields at most one event per byte
// on m_axis. Each accepted byte passes through the parser state register and the
// next-state logic straight into an output register, so a new byte is taken every
// cycle while the output register is empty or being drained; a byte that makes an
// event reaches m_axis in the cycle after it is accepted. Errors are sticky until reset.
module gif_container_deframer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // stream_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // event_kind[3:0], width[19:4], height[35:20], left[51:36], top[67:52],
    // packed_flags[75:68], color_index[84:76], palette_rgb[108:85],
    // delay_time[124:109], data_byte[132:125], error_code[135:133]
    output logic [135:0] m_axis_tdata
);

    gifd_pkg::state_t state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  sub_reg, sub_next;
    logic [8:0]  pal_rem_reg, pal_rem_next;
    logic [7:0]  pal_pos_reg, pal_pos_next;
    logic [15:0] rgb_reg, rgb_next;
    logic [63:0] desc_reg, desc_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] delay_reg, delay_next;
    logic [8:0]  transp_reg, transp_next;
    logic [2:0]  err_reg, err_next;
    logic        ovalid_reg;
    gifd_pkg::result_t res_reg, res_next;
    logic        emit;
    logic        take;
    logic [7:0]  b;
    logic [8:0]  pal_size;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign b = s_axis_tdata;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = res_reg;
    assign pal_size = 9'd2 << flags_next[2:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sub_next = sub_reg;
        pal_rem_next = pal_rem_reg;
        pal_pos_next = pal_pos_reg;
        rgb_next = rgb_reg;
        desc_next = desc_reg;
        flags_next = flags_reg;
        delay_next = delay_reg;
        transp_next = transp_reg;
        err_next = err_reg;
        res_next = '0;
        emit = 1'b0;
        case (state_reg)
            gifd_pkg::ST_SIG:
            begin
                if (b != gifd_pkg::SIGNATURE[cnt_reg[1:0]*8 +: 8])
                begin
                    err_next = gifd_pkg::ERR_HEADER;
                end
                else if (cnt_reg >= 4'd3)
                begin
                    cnt_next = '0;
                    state_next = gifd_pkg::ST_VER;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            gifd_pkg::ST_VER:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg >= 4'd1)
                begin
                    cnt_next = '0;
                    desc_next = '0;
                    state_next = gifd_pkg::ST_SCREEN;
                end
            end
            gifd_pkg::ST_SCREEN:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg < 4'd4)
                    desc_next[cnt_reg[1:0]*8 +: 8] = b;
                else if (cnt_reg == 4'd4)
                    flags_next = b;
                else if (cnt_reg == 4'd5)
                    desc_next[39:32] = b;
                else
                begin
                    emit = 1'b1;
                    res_next.event_kind = gifd_pkg::EV_SCREEN;
                    res_next.width = desc_reg[15:0];
                    res_next.height = desc_reg[31:16];
                    res_next.packed_flags = flags_reg;
                    res_next.color_index = {1'b0, desc_reg[39:32]};
                    cnt_next = '0;
                    if (flags_reg[7])
                    begin
                        pal_rem_next = pal_size;
                        pal_pos_next = '0;
                        state_next = gifd_pkg::ST_GPAL;
                    end
                    else
                        state_next = gifd_pkg::ST_BLOCK;
                end
            end
            gifd_pkg::ST_GPAL, gifd_pkg::ST_LPAL:
            begin
                if (cnt_reg == 4'd0)
                begin
                    rgb_next = {b, 8'h00};
                    cnt_next = 4'd1;
                end
                else if (cnt_reg == 4'd1)
                begin
                    rgb_next = {rgb_reg[15:8], b};
                    cnt_next = 4'd2;
                end
                else
                begin
                    emit = 1'b1;
                    res_next.event_kind = (state_reg == gifd_pkg::ST_GPAL)
                        ? gifd_pkg::EV_GLOBAL : gifd_pkg::EV_LOCAL;
                    res_next.color_index = {1'b0, pal_pos_reg};
                    res_next.palette_rgb = {rgb_reg, b};
                    pal_pos_next = pal_pos_reg + 8'd1;
                    pal_rem_next = pal_rem_reg - 9'd1;
                    cnt_next = '0;
                    if (pal_rem_next == '0)
                        state_next = (state_reg == gifd_pkg::ST_GPAL)
                            ? gifd_pkg::ST_BLOCK : gifd_pkg::ST_CODESIZE;
                end
            end
            gifd_pkg::ST_BLOCK:
            begin
                if (b == gifd_pkg::ID_IMAGE)
                begin
                    cnt_next = '0;
                    desc_next = '0;
                    state_next = gifd_pkg::ST_IMGDESC;
                end
                else if (b == gifd_pkg::ID_EXT)
                    state_next = gifd_pkg::ST_LABEL;
                else if (b == 8'h00)
                    state_next = gifd_pkg::ST_BLOCK;
                else if (b == gifd_pkg::ID_TRAILER)
                begin
                    emit = 1'b1;
                    res_next.event_kind = gifd_pkg::EV_STREAM_END;
                    state_next = gifd_pkg::ST_DONE;
                end
                else
                    err_next = gifd_pkg::ERR_BLOCK_ID;
            end
            gifd_pkg::ST_LABEL:
            begin
                cnt_next = '0;
                if (b == gifd_pkg::LBL_GCE)
                    state_next = gifd_pkg::ST_GCE;
                else if (b == gifd_pkg::LBL_APP)
                    state_next = gifd_pkg::ST_APPHDR;
                else if (b == gifd_pkg::LBL_COMMENT || b == gifd_pkg::LBL_TEXT)
                    state_next = gifd_pkg::ST_SUBCNT;
                else
                    err_next = gifd_pkg::ERR_LABEL;
            end
            gifd_pkg::ST_GCE:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                    flags_next = b;
                else if (cnt_reg == 4'd2)
                    delay_next = {8'h00, b};
                else if (cnt_reg == 4'd3)
                    delay_next = {b, delay_reg[7:0]};
                else if (cnt_reg == 4'd4)
                    transp_next = flags_reg[0] ? {1'b0, b} : gifd_pkg::NO_TRANSPARENT;
                else if (cnt_reg >= 4'd5)
                begin
                    emit = 1'b1;
                    res_next.event_kind = gifd_pkg::EV_GCE;
                    res_next.packed_flags = flags_reg;
                    res_next.color_index = transp_reg;
                    res_next.delay_time = delay_reg;
                    cnt_next = '0;
                    state_next = gifd_pkg::ST_BLOCK;
                end
            end
            gifd_pkg::ST_APPHDR:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg >= gifd_pkg::APP_HDR_LAST)
                begin
                    cnt_next = '0;
                    state_next = gifd_pkg::ST_SUBCNT;
                end
            end
            gifd_pkg::ST_SUBCNT:
            begin
                if (b == 8'h00)
                    state_next = gifd_pkg::ST_BLOCK;
                else
                begin
                    sub_next = b;
                    state_next = gifd_pkg::ST_SUBDATA;
                end
            end
            gifd_pkg::ST_SUBDATA:
            begin
                sub_next = sub_reg - 8'd1;
                if (sub_next == '0)
                    state_next = gifd_pkg::ST_SUBCNT;
            end
            gifd_pkg::ST_IMGDESC:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg < 4'd8)
                    desc_next[cnt_reg[2:0]*8 +: 8] = b;
                else
                begin
                    flags_next = b;
                    emit = 1'b1;
                    res_next.event_kind = gifd_pkg::EV_IMAGE;
                    res_next.left = desc_reg[15:0];
                    res_next.top = desc_reg[31:16];
                    res_next.width = desc_reg[47:32];
                    res_next.height = desc_reg[63:48];
                    res_next.packed_flags = b;
                    cnt_next = '0;
                    if (b[7])
                    begin
                        pal_rem_next = pal_size;
                        pal_pos_next = '0;
                        state_next = gifd_pkg::ST_LPAL;
                    end
                    else
                        state_next = gifd_pkg::ST_CODESIZE;
                end
            end
            gifd_pkg::ST_CODESIZE:
            begin
                if (b < 8'd2 || b > 8'd8)
                    err_next = gifd_pkg::ERR_CODE_SIZE;
                else
                begin
                    emit = 1'b1;
                    res_next.event_kind = gifd_pkg::EV_CODESIZE;
                    res_next.data_byte = b;
                    state_next = gifd_pkg::ST_DATACNT;
                end
            end
            gifd_pkg::ST_DATACNT:
            begin
                if (b == 8'h00)
                begin
                    emit = 1'b1;
                    res_next.event_kind = gifd_pkg::EV_DATA_END;
                    transp_next = gifd_pkg::NO_TRANSPARENT;
                    state_next = gifd_pkg::ST_BLOCK;
                end
                else
                begin
                    sub_next = b;
                    state_next = gifd_pkg::ST_DATA;
                end
            end
            gifd_pkg::ST_DATA:
            begin
                emit = 1'b1;
                res_next.event_kind = gifd_pkg::EV_DATA;
                res_next.data_byte = b;
                sub_next = sub_reg - 8'd1;
                if (sub_next == '0)
                    state_next = gifd_pkg::ST_DATACNT;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        // Any error detected above turns into the single error event.
        if (err_next != err_reg)
        begin
            emit = 1'b1;
            res_next = '0;
            res_next.event_kind = gifd_pkg::EV_ERROR;
            res_next.error_code = err_next;
            state_next = gifd_pkg::ST_ERROR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gifd_pkg::ST_SIG;
            cnt_reg <= '0;
            sub_reg <= '0;
            pal_rem_reg <= '0;
            pal_pos_reg <= '0;
            rgb_reg <= '0;
            desc_reg <= '0;
            flags_reg <= '0;
            delay_reg <= '0;
            transp_reg <= gifd_pkg::NO_TRANSPARENT;
            err_reg <= gifd_pkg::ERR_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
                cnt_reg <= cnt_next;
                sub_reg <= sub_next;
                pal_rem_reg <= pal_rem_next;
                pal_pos_reg <= pal_pos_next;
                rgb_reg <= rgb_next;
                desc_reg <= desc_next;
                flags_reg <= flags_next;
                delay_reg <= delay_next;
                transp_reg <= transp_next;
                err_reg <= err_next;
                ovalid_reg <= emit;
            end
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            res_reg <= res_next;
    end

    // An error always parks the parser in the error state.
    a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != gifd_pkg::ERR_NONE) |-> (state_reg == gifd_pkg::ST_ERROR))
        else $error("error code set outside the error state");
    // The error code never changes once set.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != gifd_pkg::ERR_NONE) |=> $stable(err_reg))
        else $error("sticky error changed");
    // After the trailer nothing more is emitted.
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (take && state_reg == gifd_pkg::ST_DONE) |=> !ovalid_reg)
        else $error("event after stream end");
    // A held output never gets overwritten by a new byte.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule

// ----- tb/gif_container_deframer_tb.sv -----
// Testbench for gif_container_deframer: directed and random GIF byte streams ending in a trailer
// or an error, checked against a built-in parser model. Depends on gifd_pkg and the RTL top.
`timescale 1ns / 1ps

module gif_container_deframer_tb;

    localparam int STALL_LIMIT = 3000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    gif_container_deframer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Parser state as seen by the model.
    gifd_pkg::state_t mdl_state;
    logic [3:0]  mdl_pos;
    logic [7:0]  mdl_sub_left;
    logic [8:0]  mdl_pal_left;
    logic [7:0]  mdl_pal_idx;
    logic [15:0] mdl_rg;
    logic [63:0] mdl_desc;
    logic [7:0]  mdl_flags;
    logic [15:0] mdl_delay;
    logic [8:0]  mdl_transp;

    gifd_pkg::result_t event_q[$];
    int      fail_count;
    int      sent_bytes;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      holdoff_cycles;
    int      quiet_cycles;

    task automatic parse_byte(input logic [7:0] b);
        gifd_pkg::result_t ev;
        bit      emit;
        ev = '0;
        emit = 1'b0;
        case (mdl_state)
            gifd_pkg::ST_SIG:
            begin
                if (b != gifd_pkg::SIGNATURE[8 * mdl_pos[1:0] +: 8])
                begin
                    mdl_state = gifd_pkg::ST_ERROR;
                    ev.event_kind = gifd_pkg::EV_ERROR;
                    ev.error_code = gifd_pkg::ERR_HEADER;
                    emit = 1'b1;
                end
                else if (mdl_pos >= 4'd3)
                begin
                    mdl_pos = '0;
                    mdl_state = gifd_pkg::ST_VER;
                end
                else
                    mdl_pos = mdl_pos + 4'd1;
            end
            gifd_pkg::ST_VER:
            begin
                if (mdl_pos >= 4'd1)
                begin
                    mdl_pos = '0;
                    mdl_desc = '0;
                    mdl_state = gifd_pkg::ST_SCREEN;
                end
                else
                    mdl_pos = mdl_pos + 4'd1;
            end
            gifd_pkg::ST_SCREEN:
            begin
                if (mdl_pos < 4'd4)
                    mdl_desc[8 * mdl_pos[1:0] +: 8] = b;
                else if (mdl_pos == 4'd4)
                    mdl_flags = b;
                else if (mdl_pos == 4'd5)
                    mdl_desc[39:32] = b;
                if (mdl_pos < 4'd6)
                    mdl_pos = mdl_pos + 4'd1;
                else
                begin
                    ev.event_kind = gifd_pkg::EV_SCREEN;
                    ev.width = mdl_desc[15:0];
                    ev.height = mdl_desc[31:16];
                    ev.packed_flags = mdl_flags;
                    ev.color_index = {1'b0, mdl_desc[39:32]};
                    emit = 1'b1;
                    mdl_pos = '0;
                    if (mdl_flags[7])
                    begin
                        mdl_pal_left = 9'd2 << mdl_flags[2:0];
                        mdl_pal_idx = '0;
                        mdl_state = gifd_pkg::ST_GPAL;
                    end
                    else
                        mdl_state = gifd_pkg::ST_BLOCK;
                end
            end
            gifd_pkg::ST_GPAL, gifd_pkg::ST_LPAL:
            begin
                if (mdl_pos == 4'd0)
                begin
                    mdl_rg = {b, 8'h00};
                    mdl_pos = 4'd1;
                end
                else if (mdl_pos == 4'd1)
                begin
                    mdl_rg[7:0] = b;
                    mdl_pos = 4'd2;
                end
                else
                begin
                    ev.event_kind = (mdl_state == gifd_pkg::ST_GPAL)
                        ? gifd_pkg::EV_GLOBAL : gifd_pkg::EV_LOCAL;
                    ev.color_index = {1'b0, mdl_pal_idx};
                    ev.palette_rgb = {mdl_rg, b};
                    emit = 1'b1;
                    mdl_pal_idx = mdl_pal_idx + 8'd1;
                    mdl_pal_left = mdl_pal_left - 9'd1;
                    mdl_pos = '0;
                    if (mdl_pal_left == '0)
                        mdl_state = (mdl_state == gifd_pkg::ST_GPAL)
                            ? gifd_pkg::ST_BLOCK : gifd_pkg::ST_CODESIZE;
                end
            end
            gifd_pkg::ST_BLOCK:
            begin
                if (b == gifd_pkg::ID_IMAGE)
                begin
                    mdl_pos = '0;
                    mdl_desc = '0;
                    mdl_state = gifd_pkg::ST_IMGDESC;
                end
                else if (b == gifd_pkg::ID_EXT)
                    mdl_state = gifd_pkg::ST_LABEL;
                else if (b == gifd_pkg::ID_TRAILER)
                begin
                    mdl_state = gifd_pkg::ST_DONE;
                    ev.event_kind = gifd_pkg::EV_STREAM_END;
                    emit = 1'b1;
                end
                else if (b != 8'h00)
                begin
                    mdl_state = gifd_pkg::ST_ERROR;
                    ev.event_kind = gifd_pkg::EV_ERROR;
                    ev.error_code = gifd_pkg::ERR_BLOCK_ID;
                    emit = 1'b1;
                end
            end
            gifd_pkg::ST_LABEL:
            begin
                mdl_pos = '0;
                if (b == gifd_pkg::LBL_GCE)
                    mdl_state = gifd_pkg::ST_GCE;
                else if (b == gifd_pkg::LBL_APP)
                    mdl_state = gifd_pkg::ST_APPHDR;
                else if (b == gifd_pkg::LBL_COMMENT || b == gifd_pkg::LBL_TEXT)
                    mdl_state = gifd_pkg::ST_SUBCNT;
                else
                begin
                    mdl_state = gifd_pkg::ST_ERROR;
                    ev.event_kind = gifd_pkg::EV_ERROR;
                    ev.error_code = gifd_pkg::ERR_LABEL;
                    emit = 1'b1;
                end
            end
            gifd_pkg::ST_GCE:
            begin
                if (mdl_pos == 4'd1)
                    mdl_flags = b;
                else if (mdl_pos == 4'd2)
                    mdl_delay = {8'h00, b};
                else if (mdl_pos == 4'd3)
                    mdl_delay[15:8] = b;
                else if (mdl_pos == 4'd4)
                    mdl_transp = mdl_flags[0] ? {1'b0, b} : gifd_pkg::NO_TRANSPARENT;
                if (mdl_pos < 4'd5)
                    mdl_pos = mdl_pos + 4'd1;
                else
                begin
                    ev.event_kind = gifd_pkg::EV_GCE;
                    ev.packed_flags = mdl_flags;
                    ev.color_index = mdl_transp;
                    ev.delay_time = mdl_delay;
                    emit = 1'b1;
                    mdl_pos = '0;
                    mdl_state = gifd_pkg::ST_BLOCK;
                end
            end
            gifd_pkg::ST_APPHDR:
            begin
                if (mdl_pos >= gifd_pkg::APP_HDR_LAST)
                begin
                    mdl_pos = '0;
                    mdl_state = gifd_pkg::ST_SUBCNT;
                end
                else
                    mdl_pos = mdl_pos + 4'd1;
            end
            gifd_pkg::ST_SUBCNT:
            begin
                if (b == 8'h00)
                    mdl_state = gifd_pkg::ST_BLOCK;
                else
                begin
                    mdl_sub_left = b;
                    mdl_state = gifd_pkg::ST_SUBDATA;
                end
            end
            gifd_pkg::ST_SUBDATA:
            begin
                mdl_sub_left = mdl_sub_left - 8'd1;
                if (mdl_sub_left == '0)
                    mdl_state = gifd_pkg::ST_SUBCNT;
            end
            gifd_pkg::ST_IMGDESC:
            begin
                if (mdl_pos < 4'd8)
                begin
                    mdl_desc[8 * mdl_pos[2:0] +: 8] = b;
                    mdl_pos = mdl_pos + 4'd1;
                end
                else
                begin
                    mdl_flags = b;
                    ev.event_kind = gifd_pkg::EV_IMAGE;
                    ev.left = mdl_desc[15:0];
                    ev.top = mdl_desc[31:16];
                    ev.width = mdl_desc[47:32];
                    ev.height = mdl_desc[63:48];
                    ev.packed_flags = b;
                    emit = 1'b1;
                    mdl_pos = '0;
                    if (b[7])
                    begin
                        mdl_pal_left = 9'd2 << b[2:0];
                        mdl_pal_idx = '0;
                        mdl_state = gifd_pkg::ST_LPAL;
                    end
                    else
                        mdl_state = gifd_pkg::ST_CODESIZE;
                end
            end
            gifd_pkg::ST_CODESIZE:
            begin
                emit = 1'b1;
                if (b < 8'd2 || b > 8'd8)
                begin
                    mdl_state = gifd_pkg::ST_ERROR;
                    ev.event_kind = gifd_pkg::EV_ERROR;
                    ev.error_code = gifd_pkg::ERR_CODE_SIZE;
                end
                else
                begin
                    ev.event_kind = gifd_pkg::EV_CODESIZE;
                    ev.data_byte = b;
                    mdl_state = gifd_pkg::ST_DATACNT;
                end
            end
            gifd_pkg::ST_DATACNT:
            begin
                if (b == 8'h00)
                begin
                    mdl_state = gifd_pkg::ST_BLOCK;
                    mdl_transp = gifd_pkg::NO_TRANSPARENT;
                    ev.event_kind = gifd_pkg::EV_DATA_END;
                    emit = 1'b1;
                end
                else
                begin
                    mdl_sub_left = b;
                    mdl_state = gifd_pkg::ST_DATA;
                end
            end
            gifd_pkg::ST_DATA:
            begin
                ev.event_kind = gifd_pkg::EV_DATA;
                ev.data_byte = b;
                emit = 1'b1;
                mdl_sub_left = mdl_sub_left - 8'd1;
                if (mdl_sub_left == '0)
                    mdl_state = gifd_pkg::ST_DATACNT;
            end
            default:
            begin
            end
        endcase
        if (emit)
            event_q.push_back(ev);
    endtask

    // Offers one byte; handshake is judged at the falling edge, where all inputs are settled.
    task automatic send_byte(input logic [7:0] b);
        bit ok;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        parse_byte(b);
        sent_bytes++;
    endtask

    task automatic send_subblocks(input int max_count, input bit big);
        int n;
        int cnt;
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
        begin
            cnt = big ? 255 : $urandom_range(1, max_count);
            send_byte(cnt[7:0]);
            for (int i = 0; i < cnt; i++)
                send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(8'h00);
    endtask

    function automatic logic [7:0] rand_pal_flags(input bit allow_big);
        logic [7:0] f;
        f = 8'($urandom_range(0, 255));
        if (!allow_big)
            f[2:1] = 2'b00;
        return f;
    endfunction

    task automatic send_header(input logic [15:0] w, input logic [15:0] h,
                               input logic [7:0] flags, input logic [7:0] bg);
        send_byte(8'h47);
        send_byte(8'h49);
        send_byte(8'h46);
        send_byte(8'h38);
        send_byte(8'h39);
        send_byte(8'h61);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
        send_byte(h[7:0]);
        send_byte(h[15:8]);
        send_byte(flags);
        send_byte(bg);
        send_byte(8'($urandom_range(0, 255)));
        if (flags[7])
            for (int i = 0; i < 3 * (2 << flags[2:0]); i++)
                send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_gce(input logic [7:0] flags, input logic [15:0] delay,
                            input logic [7:0] transp);
        send_byte(gifd_pkg::ID_EXT);
        send_byte(gifd_pkg::LBL_GCE);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(flags);
        send_byte(delay[7:0]);
        send_byte(delay[15:8]);
        send_byte(transp);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_skipped_ext(input logic [7:0] lbl);
        send_byte(gifd_pkg::ID_EXT);
        send_byte(lbl);
        if (lbl == gifd_pkg::LBL_APP)
            for (int i = 0; i <= gifd_pkg::APP_HDR_LAST; i++)
                send_byte(8'($urandom_range(0, 255)));
        send_subblocks(12, 1'b0);
    endtask

    task automatic send_image(input logic [7:0] flags, input logic [7:0] code_size,
                              input bit big_data);
        send_byte(gifd_pkg::ID_IMAGE);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(flags);
        if (flags[7])
            for (int i = 0; i < 3 * (2 << flags[2:0]); i++)
                send_byte(8'($urandom_range(0, 255)));
        send_byte(code_size);
        send_subblocks(big_data ? 255 : 16, big_data);
    endtask

    task automatic send_random_block();
        case ($urandom_range(0, 9))
            0, 1:
                send_gce(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)));
            2:
                send_skipped_ext(gifd_pkg::LBL_APP);
            3:
                send_skipped_ext($urandom_range(0, 1) ? gifd_pkg::LBL_COMMENT
                                                      : gifd_pkg::LBL_TEXT);
            4:
                send_byte(8'h00);
            default:
                send_image(rand_pal_flags(1'b0), 8'($urandom_range(2, 8)), 1'b0);
        endcase
    endtask

    task automatic test_directed();
        send_header(16'hFFFF, 16'h0000, 8'h80, 8'hFF);
        send_gce(8'h01, 16'hFFFF, 8'h00);
        send_gce(8'hFE, 16'h0000, 8'hFF);
        send_skipped_ext(gifd_pkg::LBL_APP);
        send_skipped_ext(gifd_pkg::LBL_COMMENT);
        send_skipped_ext(gifd_pkg::LBL_TEXT);
        send_byte(8'h00);
        send_image(8'h81, 8'd2, 1'b0);
        send_image(8'h00, 8'd8, 1'b1);
        // A local palette of the largest size, once.
        send_image(8'h87, 8'd5, 1'b0);
    endtask

    task automatic test_random_idling();
        int goal;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 60) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 60) : 0;
            goal = sent_bytes + 330;
            while (sent_bytes < goal)
                send_random_block();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        holdoff_cycles = 400;
        send_image(8'h00, 8'd4, 1'b1);
    endtask

    task automatic test_drain_pause();
        send_gce(8'h05, 16'h1234, 8'h42);
        s_axis_tvalid <= 1'b0;
        wait (event_q.size() == 0);
        @(posedge clk);
        send_image(8'h80, 8'd3, 1'b0);
    endtask

    // Errors are sticky and the trailer ends parsing, so exactly one terminating case is seen.
    task automatic test_termination();
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0:
                send_byte(gifd_pkg::ID_TRAILER);
            1:
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (v == 8'h00 || v == gifd_pkg::ID_IMAGE || v == gifd_pkg::ID_EXT
                       || v == gifd_pkg::ID_TRAILER);
                send_byte(v);
            end
            2:
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (v == gifd_pkg::LBL_GCE || v == gifd_pkg::LBL_APP
                       || v == gifd_pkg::LBL_COMMENT || v == gifd_pkg::LBL_TEXT);
                send_byte(gifd_pkg::ID_EXT);
                send_byte(v);
            end
            default:
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (v >= 8'd2 && v <= 8'd8);
                send_byte(gifd_pkg::ID_IMAGE);
                for (int i = 0; i < 8; i++)
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(8'h00);
                send_byte(v);
            end
        endcase
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom_range(0, 255)));
        s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            holdoff_cycles <= holdoff_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge clk)
    begin
        gifd_pkg::result_t got;
        gifd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = gifd_pkg::result_t'(m_axis_tdata);
            if (event_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected event: got %h", got);
            end
            else
            begin
                want = event_q.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("event mismatch: kind exp %0d got %0d, exp %h got %h",
                                 want.event_kind, got.event_kind, want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (!s_axis_tvalid && event_q.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        m_axis_tready = 1'b0;
        fail_count = 0;
        sent_bytes = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        quiet_cycles = 0;
        mdl_state = gifd_pkg::ST_SIG;
        mdl_pos = '0;
        mdl_sub_left = '0;
        mdl_pal_left = '0;
        mdl_pal_idx = '0;
        mdl_rg = '0;
        mdl_desc = '0;
        mdl_flags = '0;
        mdl_delay = '0;
        mdl_transp = gifd_pkg::NO_TRANSPARENT;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_idling();
        test_backpressure();
        test_drain_pause();
        test_termination();
        wait (event_q.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gifd_pkg.sv
hdl/gif_container_deframer.sv
tb/gif_container_deframer_tb.sv
